// ===== src/ast_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants for the assembly source tokenizer
// Payload structs, scan mode codes, token kinds and character classes.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Width of the line field on the result channel and of first_line
    localparam int LINE_OUT_BITS = 24;

    // Scan modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_WORD    = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;

    // Token kinds
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_DELIM  = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       source_end;
    } in_t;

    typedef struct packed {
        logic [7:0]               out_char;
        logic                     token_start;
        logic [1:0]               token_kind;
        logic [LINE_OUT_BITS-1:0] token_line;
        logic                     newline_before;
        logic                     end_reached;
        logic                     unterminated;
    } out_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
               (c == CH_COMMA)  || (c == CH_SEMI)   || (c == CH_COLON)  ||
               (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

// ===== src/assembly_source_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer: byte-stream lexer for assembly source
// Splits source bytes into tokens, one result per token character.
// ----------------------------------------------------------------------------
// Usage: feed one source byte per transfer on s_*, then a transfer with
// source_end set to close the source; that transfer always yields one result
// with end_reached set (and unterminated if a string was left open), after
// which the tokenizer is back at its reset state with the line count reloaded
// from first_line. Outside a string, whitespace and comment bytes yield no
// result; in one, an escaping backslash and the closing quote yield none.
// The input takes one byte per clock while s_ready is high: the scan mode,
// line count and newline flag are updated by a single level of logic from
// the accepted byte, and any result is registered. A second (skid) result
// register lets the input keep taking bytes while a result waits on m_ready;
// only when both hold a result does s_ready drop. No clearing pass follows reset.
// Write first_line (cfg_wr_en) only while the block is idle; a write also
// reloads the line count at once. Line numbers saturate at 2^LINE_BITS-1.
module assembly_source_tokenizer
    import ast_pkg::*;
#(
    parameter int LINE_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // source bytes
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_t                      s_data,
    // token characters
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_t                     m_data,
    // first_line register
    input  logic                     cfg_wr_en,
    input  logic [LINE_OUT_BITS-1:0] cfg_wr_data
);

    // common width for comparing first_line against the line maximum
    localparam int CMP_BITS = (LINE_BITS > LINE_OUT_BITS) ? LINE_BITS : LINE_OUT_BITS;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // state
    logic [2:0]               mode_reg, mode_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic                     nl_seen_reg, nl_seen_next;
    logic [LINE_OUT_BITS-1:0] first_line_reg;

    // output register plus skid register
    logic out_valid_reg, skid_valid_reg;
    out_t out_reg, skid_reg;

    logic accept, pop, emit, do_between;
    out_t res;
    logic [CMP_BITS-1:0] line_wide;

    function automatic logic [LINE_BITS-1:0] clamp_line(input logic [LINE_OUT_BITS-1:0] v);
        logic [CMP_BITS-1:0] v_wide;
        v_wide = CMP_BITS'(v);
        if (v_wide > CMP_BITS'(LINE_MAX)) begin
            return LINE_MAX;
        end
        return v_wide[LINE_BITS-1:0];
    endfunction

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign pop     = out_valid_reg && m_ready;

    assign line_wide = CMP_BITS'(line_reg);

    // next state and result for the byte at the input
    always_comb begin
        emit         = 1'b0;
        do_between   = 1'b0;
        mode_next    = mode_reg;
        line_next    = line_reg;
        nl_seen_next = nl_seen_reg;
        res.out_char       = s_data.in_char;
        res.token_start    = 1'b0;
        res.token_kind     = KIND_WORD;
        res.token_line     = line_wide[LINE_OUT_BITS-1:0];
        res.newline_before = 1'b0;
        res.end_reached    = 1'b0;
        res.unterminated   = 1'b0;

        if (s_data.source_end) begin
            emit               = 1'b1;
            res.out_char       = CH_NUL;
            res.newline_before = nl_seen_reg;
            res.end_reached    = 1'b1;
            res.unterminated   = (mode_reg == MODE_STRING) || (mode_reg == MODE_ESCAPE);
            mode_next          = MODE_BETWEEN;
            line_next          = clamp_line(first_line_reg);
            nl_seen_next       = 1'b0;
        end else begin
            case (mode_reg)
                MODE_COMMENT: begin
                    if (s_data.in_char == CH_NL) begin
                        if (line_reg != LINE_MAX) begin
                            line_next = line_reg + 1'b1;
                        end
                        nl_seen_next = 1'b1;
                        mode_next    = MODE_BETWEEN;
                    end
                end
                MODE_WORD: begin
                    if (is_space(s_data.in_char) || is_delim(s_data.in_char)) begin
                        do_between = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (s_data.in_char == CH_DQUOTE) begin
                        mode_next = MODE_BETWEEN;
                    end else if (s_data.in_char == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        emit           = 1'b1;
                        res.token_kind = KIND_STRING;
                    end
                end
                MODE_ESCAPE: begin
                    emit           = 1'b1;
                    res.token_kind = KIND_STRING;
                    mode_next      = MODE_STRING;
                    if (s_data.in_char == CH_LOW_N) begin
                        res.out_char = CH_NL;
                    end else if (s_data.in_char == CH_LOW_T) begin
                        res.out_char = CH_TAB;
                    end
                end
                default: begin
                    do_between = 1'b1;
                end
            endcase

            if (do_between) begin
                if (is_space(s_data.in_char)) begin
                    mode_next = MODE_BETWEEN;
                    if (s_data.in_char == CH_NL) begin
                        if (line_reg != LINE_MAX) begin
                            line_next = line_reg + 1'b1;
                        end
                        nl_seen_next = 1'b1;
                    end
                end else if (s_data.in_char == CH_SEMI) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    // new token: start mark carries the pending newline flag
                    emit               = 1'b1;
                    res.token_start    = 1'b1;
                    res.newline_before = nl_seen_reg;
                    nl_seen_next       = 1'b0;
                    if (s_data.in_char == CH_DQUOTE) begin
                        res.token_kind = KIND_STRING;
                        mode_next      = MODE_STRING;
                    end else if (is_delim(s_data.in_char)) begin
                        res.token_kind = KIND_DELIM;
                        mode_next      = MODE_BETWEEN;
                    end else begin
                        res.token_kind = KIND_WORD;
                        mode_next      = MODE_WORD;
                    end
                end
            end
        end
    end

    // scan state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_BETWEEN;
            line_reg       <= clamp_line(LINE_OUT_BITS'(1));
            nl_seen_reg    <= 1'b0;
            first_line_reg <= LINE_OUT_BITS'(1);
        end else if (cfg_wr_en) begin
            first_line_reg <= cfg_wr_data;
            line_reg       <= clamp_line(cfg_wr_data);
        end else if (accept) begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            nl_seen_reg <= nl_seen_next;
        end
    end

    // result register and skid register valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payloads
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    // skid entry only ever sits behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    // end marker returns the scanner to its idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.source_end && !cfg_wr_en) |=>
            (mode_reg == MODE_BETWEEN) && !nl_seen_reg)
        else $error("scanner not reset after end marker");

    // end result never marks a token start and carries no character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.end_reached) |->
            (!m_data.token_start && (m_data.out_char == CH_NUL)))
        else $error("malformed end-of-source result");

    // a new result cannot be dropped: stalled input only when both registers full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (out_valid_reg && skid_valid_reg))
        else $error("input stalled with free result storage");

endmodule

// ===== sim/assembly_source_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_tb: self-checking bench for the source tokenizer
// Feeds source bytes and end markers through the valid/ready input, predicts
// every token character with a behavioral lexer kept in step with the source,
// and compares each result transfer against the oldest prediction. Covers
// words, delimiters, comments, strings with escapes, end markers, line
// saturation and several first_line settings, under random idle and stall.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_tb;
    import ast_pkg::*;

    localparam int CLK_HALF_NS = 5;
    localparam int RESET_CYCLES = 11;
    // Long enough for the slowest legal run many times over
    localparam int RUN_LIMIT_NS = 2_000_000;
    // Cycles left after the last expected result before a register write;
    // the block may still be busy on a byte that produces no result
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTED = 10;
    localparam logic [LINE_OUT_BITS-1:0] LINE_MAX = {LINE_OUT_BITS{1'b1}};

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_DELIM,
        CLS_WORD
    } char_cls_e;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    in_t                      s_data      = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    out_t                     m_data;
    logic                     cfg_wr_en   = 1'b0;
    logic [LINE_OUT_BITS-1:0] cfg_wr_data = '0;

    assembly_source_tokenizer uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer state mirrored on the bench side
    // ------------------------------------------------------------------
    logic [2:0]               lex_mode       = MODE_BETWEEN;
    logic [LINE_OUT_BITS-1:0] lex_line       = LINE_OUT_BITS'(1);
    logic                     lex_nl_seen    = 1'b0;
    logic [LINE_OUT_BITS-1:0] lex_first_line = LINE_OUT_BITS'(1);

    out_t expected_chars[$];   // predicted token characters, oldest first
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   src_idle_pct   = 10;  // chance per cycle that the sender holds off
    int   sink_stall_pct = 10;  // chance per cycle that m_ready is low

    function automatic char_cls_e classify(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_NL, CH_CR: return CLS_SPACE;
            CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
            CH_COMMA, CH_SEMI, CH_COLON, CH_DQUOTE, CH_SQUOTE: return CLS_DELIM;
            default: return CLS_WORD;
        endcase
    endfunction

    // Line count saturates; flag stays set until the next token starts
    function automatic void count_newline();
        if (lex_line != LINE_MAX) begin
            lex_line++;
        end
        lex_nl_seen = 1'b1;
    endfunction

    function automatic out_t token_char(input logic [7:0] c, input logic first,
                                        input logic [1:0] kind);
        out_t r;
        r                = '0;
        r.out_char       = c;
        r.token_start    = first;
        r.token_kind     = kind;
        r.token_line     = lex_line;
        r.newline_before = first ? lex_nl_seen : 1'b0;
        if (first) begin
            lex_nl_seen = 1'b0;
        end
        return r;
    endfunction

    // Byte seen between tokens, or one that ends a word
    function automatic bit open_token(input logic [7:0] c, output out_t r);
        bit emitted;
        emitted = 1'b0;
        r       = '0;
        case (classify(c))
            CLS_SPACE: begin
                if (c == CH_NL) begin
                    count_newline();
                end
                lex_mode = MODE_BETWEEN;
            end
            CLS_DELIM: begin
                if (c == CH_SEMI) begin
                    lex_mode = MODE_COMMENT;
                end else if (c == CH_DQUOTE) begin
                    r        = token_char(c, 1'b1, KIND_STRING);
                    lex_mode = MODE_STRING;
                    emitted  = 1'b1;
                end else begin
                    r        = token_char(c, 1'b1, KIND_DELIM);
                    lex_mode = MODE_BETWEEN;
                    emitted  = 1'b1;
                end
            end
            default: begin
                r        = token_char(c, 1'b1, KIND_WORD);
                lex_mode = MODE_WORD;
                emitted  = 1'b1;
            end
        endcase
        return emitted;
    endfunction

    // Advances the mirrored lexer by one input transfer; returns 1 with the
    // expected result when the transfer produces one
    function automatic bit predict_token_char(input in_t item, output out_t r);
        logic [7:0] c;
        logic [7:0] resolved;
        bit         emitted;
        c       = item.in_char;
        emitted = 1'b0;
        r       = '0;
        if (item.source_end) begin
            r.token_line     = lex_line;
            r.newline_before = lex_nl_seen;
            r.end_reached    = 1'b1;
            r.unterminated   = (lex_mode == MODE_STRING) || (lex_mode == MODE_ESCAPE);
            lex_mode         = MODE_BETWEEN;
            lex_line         = lex_first_line;
            lex_nl_seen      = 1'b0;
            emitted          = 1'b1;
        end else begin
            case (lex_mode)
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        count_newline();
                        lex_mode = MODE_BETWEEN;
                    end
                end
                MODE_WORD: begin
                    if (classify(c) == CLS_WORD) begin
                        r       = token_char(c, 1'b0, KIND_WORD);
                        emitted = 1'b1;
                    end else begin
                        emitted = open_token(c, r);
                    end
                end
                MODE_STRING: begin
                    // raw newlines stay in the string and are not counted
                    if (c == CH_DQUOTE) begin
                        lex_mode = MODE_BETWEEN;
                    end else if (c == CH_BSLASH) begin
                        lex_mode = MODE_ESCAPE;
                    end else begin
                        r       = token_char(c, 1'b0, KIND_STRING);
                        emitted = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    resolved = (c == CH_LOW_N) ? CH_NL : (c == CH_LOW_T) ? CH_TAB : c;
                    r        = token_char(resolved, 1'b0, KIND_STRING);
                    lex_mode = MODE_STRING;
                    emitted  = 1'b1;
                end
                default: emitted = open_token(c, r);
            endcase
        end
        return emitted;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall on m_ready, check on every transfer
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED) begin
                    $display("unexpected result: char %02h start %0d kind %0d line %06h",
                             m_data.out_char, m_data.token_start, m_data.token_kind,
                             m_data.token_line);
                end
            end else begin
                want = expected_chars.pop_front();
                if ((m_data.out_char       !== want.out_char)       ||
                    (m_data.token_start    !== want.token_start)    ||
                    (m_data.token_kind     !== want.token_kind)     ||
                    (m_data.token_line     !== want.token_line)     ||
                    (m_data.newline_before !== want.newline_before) ||
                    (m_data.end_reached    !== want.end_reached)    ||
                    (m_data.unterminated   !== want.unterminated)) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED) begin
                        $display({"mismatch at %0t: char/start/kind/line/nl/end/unterm ",
                                  "exp %02h %0d %0d %06h %0d %0d %0d got %02h %0d %0d %06h ",
                                  "%0d %0d %0d"}, $realtime,
                                 want.out_char, want.token_start, want.token_kind,
                                 want.token_line, want.newline_before, want.end_reached,
                                 want.unterminated,
                                 m_data.out_char, m_data.token_start, m_data.token_kind,
                                 m_data.token_line, m_data.newline_before,
                                 m_data.end_reached, m_data.unterminated);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side. All tasks start and return at a falling edge; valid is
    // left high after a transfer so back-to-back bytes never drop it.
    // ------------------------------------------------------------------
    task automatic send_item(input in_t item);
        out_t r;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        if (predict_token_char(item, r)) begin
            expected_chars.push_back(r);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        in_t item;
        item.in_char    = c;
        item.source_end = 1'b0;
        send_item(item);
    endtask

    // End marker; the byte lane carries junk that must be ignored
    task automatic close_source();
        in_t item;
        item.in_char    = 8'($urandom_range(255));
        item.source_end = 1'b1;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // Sender holds off until the block has nothing left in flight
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writing first_line also reloads the running line count
    task automatic set_first_line(input logic [LINE_OUT_BITS-1:0] value);
        drain_results();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en      <= 1'b0;
        lex_first_line  = value;
        lex_line        = value;
    endtask

    // ------------------------------------------------------------------
    // Random source text: mostly assembly-shaped lines
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_word_char();
        logic [7:0] c;
        c = "a" + 8'($urandom_range(25));
        if ($urandom_range(3) == 0) begin
            do c = 8'($urandom_range(255)); while (classify(c) != CLS_WORD);
        end
        return c;
    endfunction

    task automatic send_word();
        repeat ($urandom_range(1, 6)) send_char(random_word_char());
    endtask

    task automatic send_blank();
        repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(3))
                0: send_char(CH_TAB);
                1: send_char(CH_CR);
                default: send_char(CH_SPACE);
            endcase
        end
    endtask

    task automatic send_quoted();
        send_char(CH_DQUOTE);
        repeat ($urandom_range(8)) begin
            case ($urandom_range(9))
                0: begin
                    send_char(CH_BSLASH);
                    case ($urandom_range(4))
                        0: send_char(CH_LOW_N);
                        1: send_char(CH_LOW_T);
                        2: send_char(CH_DQUOTE);
                        3: send_char(CH_BSLASH);
                        default: send_char(8'($urandom_range(255)));
                    endcase
                end
                1: send_char(CH_NL);
                2: send_char(8'($urandom_range(255)));
                3: send_char(CH_SPACE);
                default: send_char(random_word_char());
            endcase
        end
        // an open string swallows what follows until the next quote
        if ($urandom_range(9) != 0) begin
            send_char(CH_DQUOTE);
        end
    endtask

    task automatic send_random_line();
        int n_ops;
        n_ops = $urandom_range(3);
        if ($urandom_range(3) == 0) begin
            send_word();
            send_char(CH_COLON);
        end
        if ($urandom_range(1)) begin
            send_blank();
        end
        send_word();
        for (int i = 0; i < n_ops; i++) begin
            if (i != 0) begin
                send_char(CH_COMMA);
            end
            if ($urandom_range(1)) begin
                send_blank();
            end
            case ($urandom_range(6))
                0: begin
                    send_char(CH_LBRACK);
                    send_word();
                    send_char(CH_RBRACK);
                end
                1: begin
                    send_char(CH_LPAREN);
                    send_word();
                    send_char(CH_RPAREN);
                end
                2: begin
                    send_char(CH_LBRACE);
                    send_word();
                    send_char(CH_RBRACE);
                end
                3: send_quoted();
                4: begin
                    send_char(CH_SQUOTE);
                    send_word();
                end
                default: send_word();
            endcase
        end
        // trailing comment; the word may run right into the semicolon
        if ($urandom_range(3) == 0) begin
            if ($urandom_range(1)) begin
                send_blank();
            end
            send_char(CH_SEMI);
            repeat ($urandom_range(6)) send_char(8'($urandom_range(255)));
        end
        if ($urandom_range(4) == 0) begin
            send_char(CH_CR);
        end
        send_char(CH_NL);
    endtask

    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            send_random_line();
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)));
        end else if (pick < 94) begin
            close_source();
        end else begin
            // source cut off inside a string, sometimes right after a backslash
            send_char(CH_DQUOTE);
            repeat ($urandom_range(3)) send_char(random_word_char());
            if ($urandom_range(1)) begin
                send_char(CH_BSLASH);
            end
            close_source();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Byte extremes as word characters, a word ended by a comment, and each
    // kind of whitespace
    task automatic test_words_and_comments();
        send_char(8'hFF);
        send_char(CH_NUL);
        send_text(";c");
        send_char(CH_NL);
        send_char(CH_CR);
        send_char(CH_TAB);
        send_char(CH_SPACE);
    endtask

    // The bracket, comma, colon and single-quote delimiters, then an end marker after a newline
    task automatic test_delimiters();
        send_text("(){}[],:'");
        send_char(CH_NL);
        close_source();
    endtask

    // Escapes, a raw newline kept in a string, the dropped closing quote,
    // and the source ending inside a string and inside an escape
    task automatic test_strings();
        send_text("\"a\\n\\t\\q\n\"");
        send_text("\"x");
        close_source();
        send_text("\"\\");
        close_source();
    endtask

    // Line count saturation at the top, reload on end marker, first_line 0
    task automatic test_line_limits();
        set_first_line(LINE_OUT_BITS'(LINE_MAX - 1));
        send_text("\n\nw\n");
        close_source();
        send_char("w");
        set_first_line('0);
        send_char("a");
        close_source();
    endtask

    task automatic test_random_source(input logic [LINE_OUT_BITS-1:0] first,
                                      input int n_items, input int idle_pct);
        int stop_at;
        set_first_line(first);
        src_idle_pct   = idle_pct;
        sink_stall_pct = idle_pct;
        stop_at = items_sent + n_items / 2;
        while (items_sent < stop_at) send_random_chunk();
        drain_results();
        stop_at = items_sent + n_items - n_items / 2;
        while (items_sent < stop_at) send_random_chunk();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_words_and_comments();
        test_delimiters();
        test_strings();
        test_line_limits();
        test_random_source(24'($urandom_range(1, 1000)), 400, 10);
        // long stretch with neither side idling; starts near the line limit
        test_random_source(LINE_OUT_BITS'(LINE_MAX - 7), 350, 0);
        test_random_source('0, 350, 10);
        test_random_source(24'($urandom), 300, 10);

        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("assembly_source_tokenizer_tb OK");
        end else begin
            $display("assembly_source_tokenizer_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("assembly_source_tokenizer_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/ast_pkg.sv
src/assembly_source_tokenizer.sv
sim/assembly_source_tokenizer_tb.sv
